// File: hw/rtl/ssd_pkg.sv
// Shared types, codes and segment glyphs for the seven-segment scan controller.
// Used by ssd_ctrl, ssd_datapath and the top level; depends on nothing else.
package ssd_pkg;

    localparam int DIGIT_COUNT = 4;
    localparam int POS_W       = $clog2(DIGIT_COUNT);

    // Segment bits: bit0 is segment a up to bit6 g, bit7 the decimal point.
    localparam logic [7:0] SEG_A = 8'h01;
    localparam logic [7:0] SEG_B = 8'h02;
    localparam logic [7:0] SEG_C = 8'h04;
    localparam logic [7:0] SEG_D = 8'h08;
    localparam logic [7:0] SEG_E = 8'h10;
    localparam logic [7:0] SEG_F = 8'h20;
    localparam logic [7:0] SEG_G = 8'h40;

    localparam logic [7:0] GLYPH_MINUS = SEG_G;
    localparam logic [7:0] GLYPH_E     = SEG_A | SEG_D | SEG_E | SEG_F | SEG_G;
    localparam logic [7:0] GLYPH_R     = SEG_E | SEG_G;

    localparam logic signed [15:0] SHOW_MAX = 16'sd9999;
    localparam logic signed [15:0] SHOW_MIN = -16'sd999;

    // 13108 / 2^17 is close enough to 1/10 for every magnitude up to 9999.
    localparam logic [13:0] RECIP_TEN = 14'd13108;
    localparam int          RECIP_SH  = 17;

    typedef enum logic [1:0] {
        FUNC_TICK     = 2'd0,
        FUNC_SHOW_INT = 2'd1,
        FUNC_SET_RAW  = 2'd2,
        FUNC_CLEAR    = 2'd3
    } func_t;

    // Register index of the configuration port.
    localparam logic REG_COMMON_ANODE = 1'b0;

    typedef struct packed {
        logic accept;     // an item is taken this cycle
        logic conv_step;  // produce one decimal digit
        logic emit;       // load the output register
    } ssd_cmd_t;

    typedef struct packed {
        logic int_conv;   // current input is a show-integer item within range
        logic conv_last;  // the digit produced this cycle is the final one
    } ssd_sts_t;

    function automatic logic [7:0] digit_glyph(input logic [3:0] d);
        logic [7:0] g;
        case (d)
            4'd0:    g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F;
            4'd1:    g = SEG_B | SEG_C;
            4'd2:    g = SEG_A | SEG_B | SEG_D | SEG_E | SEG_G;
            4'd3:    g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_G;
            4'd4:    g = SEG_B | SEG_C | SEG_F | SEG_G;
            4'd5:    g = SEG_A | SEG_C | SEG_D | SEG_F | SEG_G;
            4'd6:    g = SEG_A | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
            4'd7:    g = SEG_A | SEG_B | SEG_C;
            4'd8:    g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_E | SEG_F | SEG_G;
            4'd9:    g = SEG_A | SEG_B | SEG_C | SEG_D | SEG_F | SEG_G;
            default: g = 8'h00;
        endcase
        return g;
    endfunction

endpackage

// File: hw/rtl/ssd_ctrl.sv
// Control state machine: item acceptance, digit conversion sequencing and
// output register handshake. Depends on ssd_pkg.
module ssd_ctrl
    import ssd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    output logic     out_valid,
    input  logic     out_stall,
    input  ssd_sts_t sts,
    output ssd_cmd_t cmd
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_CONV = 3'b010,
        ST_EMIT = 3'b100
    } ctrl_state_t;

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;
    logic        slot_free;

    assign slot_free     = !out_valid_reg || !out_stall;
    assign in_stall      = (state_reg != ST_IDLE);
    assign out_valid     = out_valid_reg;
    assign cmd.accept    = (state_reg == ST_IDLE) && in_valid;
    assign cmd.conv_step = (state_reg == ST_CONV);
    assign cmd.emit      = (state_reg == ST_EMIT) && slot_free;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (cmd.accept)
                begin
                    state_next = sts.int_conv ? ST_CONV : ST_EMIT;
                end
            end
            ST_CONV:
            begin
                if (sts.conv_last)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (cmd.emit)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        if (cmd.emit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef NO_ASSERTIONS
    // A result is loaded exactly once, and the machine is free again after it.
    a_emit_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |=> (state_reg == ST_IDLE) && out_valid_reg)
        else $error("emit did not return to idle with a valid result");

    // Conversion never starts without an accepted item leading into it.
    a_conv_entry: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmd.conv_step) |-> $past(cmd.accept) && $past(sts.int_conv))
        else $error("conversion entered without an accepted show-integer item");

    // A stalled result stays offered until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |=> out_valid_reg)
        else $error("stalled result withdrawn");
`endif

endmodule

// File: hw/rtl/ssd_datapath.sv
// Datapath: segment store, scan position, pin drive, decimal conversion unit
// (one digit per cycle by reciprocal multiply) and output payload registers.
// Depends on ssd_pkg.
module ssd_datapath
    import ssd_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  ssd_cmd_t            cmd,
    output ssd_sts_t            sts,
    input  logic [1:0]          func,
    input  logic signed [15:0]  value,
    input  logic                leading_zeros,
    input  logic [2:0]          digit_index,
    input  logic [7:0]          segment_mask,
    input  logic                common_anode,
    output logic [DIGIT_COUNT-1:0] digit_lines,
    output logic [7:0]          segment_lines,
    output logic                range_error
);

    logic [7:0]             store_reg [DIGIT_COUNT];
    logic [7:0]             store_next [DIGIT_COUNT];
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [DIGIT_COUNT-1:0] lit_reg, lit_next;
    logic [7:0]             drv_reg, drv_next;
    logic                   err_reg, err_next;

    logic [13:0]            mag_reg;
    logic [POS_W-1:0]       n_reg;
    logic                   neg_reg;
    logic                   pad_reg;

    logic [DIGIT_COUNT-1:0] dig_out_reg;
    logic [7:0]             seg_out_reg;
    logic                   err_out_reg;

    logic                   in_range;
    logic                   in_neg;
    logic [15:0]            in_abs;
    logic [27:0]            prod;
    logic [13:0]            quot;
    logic [13:0]            rem_full;
    logic [3:0]             rem;
    logic [POS_W:0]         n_inc;
    logic [POS_W:0]         width;
    logic                   more;

    assign in_neg   = value[15];
    assign in_range = (value <= SHOW_MAX) && (value >= SHOW_MIN);
    assign in_abs   = in_neg ? 16'(-value) : value;

    // Quotient and remainder of the magnitude by ten.
    assign prod     = 28'(mag_reg) * 28'(RECIP_TEN);
    assign quot     = 14'(prod >> RECIP_SH);
    assign rem_full = mag_reg - 14'((quot << 3) + (quot << 1));
    assign rem      = rem_full[3:0];

    assign n_inc = {1'b0, n_reg} + (POS_W+1)'(1);
    assign width = neg_reg ? (POS_W+1)'(DIGIT_COUNT - 1) : (POS_W+1)'(DIGIT_COUNT);
    assign more  = ((quot != 14'd0) || (pad_reg && (n_inc < width)))
                   && (n_inc < (POS_W+1)'(DIGIT_COUNT));

    assign sts.int_conv  = (func == FUNC_SHOW_INT) && in_range;
    assign sts.conv_last = !more;

    always_comb
    begin
        for (int i = 0; i < DIGIT_COUNT; i++)
        begin
            store_next[i] = store_reg[i];
        end
        pos_next = pos_reg;
        lit_next = lit_reg;
        drv_next = drv_reg;
        err_next = err_reg;

        if (cmd.accept)
        begin
            err_next = 1'b0;
            case (func)
                FUNC_TICK:
                begin
                    drv_next = store_reg[pos_reg];
                    lit_next = DIGIT_COUNT'(1) << pos_reg;
                    pos_next = pos_reg + POS_W'(1);
                end
                FUNC_SHOW_INT:
                begin
                    for (int i = 0; i < DIGIT_COUNT; i++)
                    begin
                        store_next[i] = 8'h00;
                    end
                    if (!in_range)
                    begin
                        store_next[0] = GLYPH_E;
                        store_next[1] = GLYPH_R;
                        store_next[2] = GLYPH_R;
                        err_next      = 1'b1;
                    end
                end
                FUNC_SET_RAW:
                begin
                    if (digit_index < 3'(DIGIT_COUNT))
                    begin
                        store_next[digit_index[POS_W-1:0]] = segment_mask;
                    end
                end
                default:
                begin
                    for (int i = 0; i < DIGIT_COUNT; i++)
                    begin
                        store_next[i] = 8'h00;
                    end
                    lit_next = '0;
                    drv_next = 8'h00;
                end
            endcase
        end
        else if (cmd.conv_step)
        begin
            // Digits fill from the right; the minus sign goes just left of them.
            store_next[~n_reg] = digit_glyph(rem);
            if (!more && neg_reg && (n_reg != POS_W'(DIGIT_COUNT - 1)))
            begin
                store_next[~n_inc[POS_W-1:0]] = GLYPH_MINUS;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                store_reg[i] <= 8'h00;
            end
            pos_reg <= '0;
            lit_reg <= '0;
            drv_reg <= 8'h00;
            err_reg <= 1'b0;
        end
        else
        begin
            for (int i = 0; i < DIGIT_COUNT; i++)
            begin
                store_reg[i] <= store_next[i];
            end
            pos_reg <= pos_next;
            lit_reg <= lit_next;
            drv_reg <= drv_next;
            err_reg <= err_next;
        end
    end

    // Conversion working registers need no reset: they are loaded on accept.
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mag_reg <= in_abs[13:0];
            neg_reg <= in_neg;
            pad_reg <= leading_zeros;
            n_reg   <= '0;
        end
        else if (cmd.conv_step)
        begin
            mag_reg <= quot;
            n_reg   <= n_inc[POS_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            dig_out_reg <= common_anode ? lit_reg : ~lit_reg;
            seg_out_reg <= common_anode ? ~drv_reg : drv_reg;
            err_out_reg <= err_reg;
        end
    end

    assign digit_lines   = dig_out_reg;
    assign segment_lines = seg_out_reg;
    assign range_error   = err_out_reg;

`ifndef NO_ASSERTIONS
    a_lit_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(lit_reg))
        else $error("more than one digit lit");

    a_conv_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.conv_step && (n_reg == POS_W'(DIGIT_COUNT - 1))) |-> sts.conv_last)
        else $error("conversion ran past the last digit");

    a_err_glyphs: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.emit && err_reg) |-> (store_reg[0] == GLYPH_E) && (store_reg[1] == GLYPH_R))
        else $error("range error without the error text in the store");
`endif

endmodule

// File: hw/rtl/seven_segment_scan_controller.sv
// Four-digit multiplexed seven-segment controller, top level with APB register.
// Tick, set raw, clear and out-of-range show integer: accept, then output load.
// In-range show integer: one conversion step per decimal digit between the two.
// Input stalls until the load. A result held by out_stall delays the next load.
// Reset (rst_n, asynchronous, active low) clears the store, scan position and drive
// registers, not the pins, and sets common_anode to 0; no clearing pass is needed.
module seven_segment_scan_controller
    import ssd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [2:0]             paddr,
    input  logic [31:0]            pwdata,
    output logic [31:0]            prdata,
    output logic                   pready,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [1:0]             func,
    input  logic signed [15:0]     value,
    input  logic                   leading_zeros,
    input  logic [2:0]             digit_index,
    input  logic [7:0]             segment_mask,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [DIGIT_COUNT-1:0] digit_lines,
    output logic [7:0]             segment_lines,
    output logic                   range_error
);

    logic     common_anode_reg, common_anode_next;
    logic     reg_sel;
    ssd_cmd_t cmd;
    ssd_sts_t sts;

    assign pready  = 1'b1;
    assign reg_sel = (paddr[2] == REG_COMMON_ANODE);
    assign prdata  = reg_sel ? {31'd0, common_anode_reg} : 32'd0;

    always_comb
    begin
        common_anode_next = common_anode_reg;
        if (psel && penable && pwrite && pready && reg_sel)
        begin
            common_anode_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            common_anode_reg <= 1'b0;
        end
        else
        begin
            common_anode_reg <= common_anode_next;
        end
    end

    ssd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ssd_datapath u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .func          (func),
        .value         (value),
        .leading_zeros (leading_zeros),
        .digit_index   (digit_index),
        .segment_mask  (segment_mask),
        .common_anode  (common_anode_reg),
        .digit_lines   (digit_lines),
        .segment_lines (segment_lines),
        .range_error   (range_error)
    );

endmodule
